### rtl/core/tdsp_pkg.sv
// Shared types and constants for the TLV dictionary stream parser.
// No dependencies; imported by every module of the parser.
`default_nettype none

package tdsp_pkg;

   // Configuration port
   localparam int CsrIndexBits = 4;
   localparam int CsrDataBits  = 16;
   localparam logic [CsrIndexBits-1:0] CSR_MAX_VERSION = 4'd0;
   localparam logic [CsrIndexBits-1:0] CSR_END_TYPE    = 4'd1;
   localparam logic [15:0] MAX_VERSION_RESET = 16'h0100;
   localparam logic [7:0]  END_TYPE_RESET    = 8'h00;

   // Queue between front and back
   localparam int QueueDepth   = 4;
   localparam int QueuePtrBits = 2;
   localparam int QueueCntBits = 3;

   // Byte roles
   localparam logic [2:0] ROLE_VERSION = 3'd0;
   localparam logic [2:0] ROLE_TYPE    = 3'd1;
   localparam logic [2:0] ROLE_KEY_LEN = 3'd2;
   localparam logic [2:0] ROLE_KEY     = 3'd3;
   localparam logic [2:0] ROLE_VAL_LEN = 3'd4;
   localparam logic [2:0] ROLE_VALUE   = 3'd5;
   localparam logic [2:0] ROLE_END     = 3'd6;

   // Error codes
   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_BAD_VERSION = 3'd1;
   localparam logic [2:0] ERR_SHORT_HDR   = 3'd2;
   localparam logic [2:0] ERR_SHORT_TYPE  = 3'd3;
   localparam logic [2:0] ERR_SHORT_KLEN  = 3'd4;
   localparam logic [2:0] ERR_SHORT_KEY   = 3'd5;
   localparam logic [2:0] ERR_SHORT_VLEN  = 3'd6;
   localparam logic [2:0] ERR_SHORT_VALUE = 3'd7;

   // Parse phases
   typedef enum logic [2:0] {
      PH_VER0  = 3'd0,
      PH_VER1  = 3'd1,
      PH_TYPE  = 3'd2,
      PH_KLEN  = 3'd3,
      PH_KEY   = 3'd4,
      PH_VLEN  = 3'd5,
      PH_VALUE = 3'd6
   } phase_type;

   // Classified byte carried from front to back
   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
      logic       is_end_code;
      logic       ver_bad;
   } entry_type;

   // Error for a stream that stops while the given phase is still due
   function automatic logic [2:0] short_code(input phase_type ph);
      logic [2:0] code;
      code = ERR_NONE;
      case (ph)
         PH_VER1:  code = ERR_SHORT_HDR;
         PH_TYPE:  code = ERR_SHORT_TYPE;
         PH_KLEN:  code = ERR_SHORT_KLEN;
         PH_KEY:   code = ERR_SHORT_KEY;
         PH_VLEN:  code = ERR_SHORT_VLEN;
         PH_VALUE: code = ERR_SHORT_VALUE;
         default:  code = ERR_NONE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

### rtl/core/tdsp_front.sv
// Front end: accepts input bytes and classifies them against the config.
// Depends on tdsp_pkg; feeds tdsp_queue.
`default_nettype none

module tdsp_front
   import tdsp_pkg::*;
(
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_stream_end,
   input  wire logic [15:0] max_version,
   input  wire logic [7:0]  end_type_code,
   input  wire logic        queue_full,
   output logic             push,
   output entry_type        push_entry
);

   // Hold off the source while the queue has no room
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Precompute the end-marker match and the masked version check
   always_comb begin
      push_entry.data_byte   = req_data_byte;
      push_entry.stream_end  = req_stream_end;
      push_entry.is_end_code = (req_data_byte == end_type_code);
      push_entry.ver_bad     = ({req_data_byte, 8'h00} > max_version);
   end

endmodule

`default_nettype wire

### rtl/core/tdsp_queue.sv
// Short register queue between the classifier front and the parse back end.
// Depends on tdsp_pkg for the entry type and depth.
`default_nettype none

module tdsp_queue
   import tdsp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output logic           full,
   input  wire logic      pop,
   output logic           head_valid,
   output entry_type      head_entry
);

   entry_type                slot_ff [QueueDepth];
   logic [QueuePtrBits-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrBits-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QueueCntBits-1:0]  count_ff, count_in;

   assign full       = (count_ff == QueueCntBits'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed transaction
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

### rtl/core/tdsp_back.sv
// Back end: parse state machine and registered result stage.
// Depends on tdsp_pkg; consumes the head of tdsp_queue.
`default_nettype none

module tdsp_back
   import tdsp_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      head_valid,
   input  wire entry_type head_entry,
   output logic           pop,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output logic [2:0]     rsp_byte_role,
   output logic [31:0]    rsp_field_position,
   output logic           rsp_field_last,
   output logic [7:0]     rsp_entry_type,
   output logic [31:0]    rsp_length_value,
   output logic [2:0]     rsp_error_code,
   output logic           rsp_dictionary_done
);

   localparam logic [31:0] LenLimit = 32'((33'd1 << LENGTH_BITS) - 33'd1);

   phase_type               phase_ff, phase_in, phase_step;
   logic [LENGTH_BITS-1:0]  pos_ff, pos_in;
   logic [LENGTH_BITS-1:0]  rem_ff, rem_in;
   logic [31:0]             acc_ff, acc_in;
   logic [7:0]              type_ff, type_in;

   logic                    valid_ff;
   logic [2:0]              role_ff, role_in;
   logic [31:0]             fpos_ff, fpos_in;
   logic                    last_ff, last_in;
   logic [7:0]              etype_ff, etype_in;
   logic [31:0]             lenv_ff, lenv_in;
   logic [2:0]              err_ff, err_in;
   logic                    done_ff, done_in;

   logic [1:0]              k;
   logic [31:0]             acc_base;
   logic [31:0]             acc_new;
   logic [31:0]             clamped;
   logic [LENGTH_BITS-1:0]  len_count;
   logic                    rem_last;
   logic [2:0]              base_err;

   // Take the next transaction when the result stage is free or draining
   assign pop = head_valid && (!valid_ff || !rsp_stall);

   // Assemble little-endian length and clamp it to the counter width
   always_comb begin
      k         = pos_ff[1:0];
      acc_base  = (k == 2'd0) ? 32'd0 : acc_ff;
      acc_new   = acc_base | (32'(head_entry.data_byte) << {k, 3'b000});
      clamped   = (acc_new > LenLimit) ? LenLimit : acc_new;
      len_count = clamped[LENGTH_BITS-1:0];
      rem_last  = (rem_ff == '0) || (rem_ff == LENGTH_BITS'(1));
   end

   // Next phase
   always_comb begin
      phase_step = PH_VER1;
      unique case (phase_ff)
         PH_VER0:  phase_step = PH_VER1;
         PH_VER1:  phase_step = head_entry.ver_bad ? PH_VER1 : PH_TYPE;
         PH_TYPE:  phase_step = head_entry.is_end_code ? PH_VER0 : PH_KLEN;
         PH_KLEN: begin
            if (k == 2'd3) begin
               phase_step = (len_count != '0) ? PH_KEY : PH_VLEN;
            end else begin
               phase_step = PH_KLEN;
            end
         end
         PH_VLEN: begin
            if (k == 2'd3) begin
               phase_step = (len_count != '0) ? PH_VALUE : PH_TYPE;
            end else begin
               phase_step = PH_VLEN;
            end
         end
         PH_KEY:   phase_step = rem_last ? PH_VLEN : PH_KEY;
         PH_VALUE: phase_step = rem_last ? PH_TYPE : PH_VALUE;
         default:  phase_step = PH_VER1;
      endcase
      // Restart the dictionary after any error
      phase_in = (err_in != ERR_NONE) ? PH_VER0 : phase_step;
   end

   // Result fields and counter updates
   always_comb begin
      role_in  = ROLE_VERSION;
      fpos_in  = 32'd0;
      last_in  = 1'b0;
      etype_in = 8'd0;
      lenv_in  = 32'd0;
      done_in  = 1'b0;
      base_err = ERR_NONE;
      pos_in   = pos_ff;
      rem_in   = rem_ff;
      acc_in   = acc_ff;
      type_in  = type_ff;
      unique case (phase_ff) inside
         PH_VER1: begin
            fpos_in  = 32'd1;
            last_in  = 1'b1;
            base_err = head_entry.ver_bad ? ERR_BAD_VERSION : ERR_NONE;
         end
         PH_TYPE: begin
            last_in  = 1'b1;
            etype_in = head_entry.data_byte;
            if (head_entry.is_end_code) begin
               role_in = ROLE_END;
               done_in = 1'b1;
            end else begin
               role_in = ROLE_TYPE;
               type_in = head_entry.data_byte;
               pos_in  = '0;
               acc_in  = 32'd0;
            end
         end
         PH_KLEN, PH_VLEN: begin
            role_in  = (phase_ff == PH_KLEN) ? ROLE_KEY_LEN : ROLE_VAL_LEN;
            fpos_in  = 32'(k);
            etype_in = type_ff;
            lenv_in  = acc_new;
            if (k == 2'd3) begin
               last_in = 1'b1;
               rem_in  = len_count;
               pos_in  = '0;
               acc_in  = 32'd0;
            end else begin
               pos_in  = LENGTH_BITS'(k) + LENGTH_BITS'(1);
               acc_in  = acc_new;
            end
         end
         PH_KEY, PH_VALUE: begin
            role_in  = (phase_ff == PH_KEY) ? ROLE_KEY : ROLE_VALUE;
            fpos_in  = 32'(pos_ff);
            etype_in = type_ff;
            if (rem_last) begin
               last_in = 1'b1;
               rem_in  = '0;
               pos_in  = '0;
            end else begin
               rem_in  = rem_ff - LENGTH_BITS'(1);
               pos_in  = pos_ff + LENGTH_BITS'(1);
            end
         end
         default: begin
            // First version byte; only the high byte enters the check
            role_in = ROLE_VERSION;
         end
      endcase

      // Flag a bad version, or a stream that stops before the dictionary is complete
      if (base_err != ERR_NONE) begin
         err_in = base_err;
      end else if (!done_in && head_entry.stream_end) begin
         err_in = short_code(phase_step);
      end else begin
         err_in = ERR_NONE;
      end

      if (err_in != ERR_NONE) begin
         pos_in = '0;
         rem_in = '0;
         acc_in = 32'd0;
      end
   end

   // Parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_VER0;
         pos_ff   <= '0;
         rem_ff   <= '0;
         acc_ff   <= 32'd0;
         type_ff  <= 8'd0;
      end else if (pop) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         rem_ff   <= rem_in;
         acc_ff   <= acc_in;
         type_ff  <= type_in;
      end
   end

   // Result register: load on pop, hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!valid_ff || !rsp_stall) begin
         valid_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         role_ff  <= role_in;
         fpos_ff  <= fpos_in;
         last_ff  <= last_in;
         etype_ff <= etype_in;
         lenv_ff  <= lenv_in;
         err_ff   <= err_in;
         done_ff  <= done_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_byte_role       = role_ff;
   assign rsp_field_position  = fpos_ff;
   assign rsp_field_last      = last_ff;
   assign rsp_entry_type      = etype_ff;
   assign rsp_length_value    = lenv_ff;
   assign rsp_error_code      = err_ff;
   assign rsp_dictionary_done = done_ff;

endmodule

`default_nettype wire

### rtl/core/tlv_dictionary_stream_parser_core.sv
// Top level of the TLV dictionary stream parser: config registers and wiring.
// Depends on tdsp_pkg, tdsp_front, tdsp_queue and tdsp_back.
`default_nettype none

// Parses a serialized variant dictionary one byte per transaction and returns
// one result per byte (role, position in field, field-last flag, entry type,
// assembled length, error code, end-marker flag). Throughput is one byte per
// clock while the result is not stalled: an accepted byte lands in the
// four-entry classification queue, and the parse stage loads it into the
// result register when that register is free. While the result is stalled
// the queue absorbs four more bytes, then req_stall rises. The parse stage's
// single 32-bit length assemble and clamp sets the critical path. LENGTH_BITS
// (8 to 32) is the width of the key/value byte counters; lengths above
// 2^LENGTH_BITS-1 saturate. Write the config registers (0: max_version,
// 1: end_type_code) only while no byte is in flight.
module tlv_dictionary_stream_parser_core
   import tdsp_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [7:0]              req_data_byte,
   input  wire logic                    req_stream_end,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [2:0]                   rsp_byte_role,
   output logic [31:0]                  rsp_field_position,
   output logic                         rsp_field_last,
   output logic [7:0]                   rsp_entry_type,
   output logic [31:0]                  rsp_length_value,
   output logic [2:0]                   rsp_error_code,
   output logic                         rsp_dictionary_done,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CsrIndexBits-1:0] csr_index,
   input  wire logic [CsrDataBits-1:0]  csr_wdata
);

   logic [15:0] max_version_ff;
   logic [7:0]  end_type_ff;
   logic        queue_full;
   logic        push;
   entry_type   push_entry;
   logic        pop;
   logic        head_valid;
   entry_type   head_entry;

   // Config writes are always accepted
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_version_ff <= MAX_VERSION_RESET;
         end_type_ff    <= END_TYPE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_VERSION: max_version_ff <= csr_wdata;
            CSR_END_TYPE:    end_type_ff    <= csr_wdata[7:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   tdsp_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_stream_end (req_stream_end),
      .max_version    (max_version_ff),
      .end_type_code  (end_type_ff),
      .queue_full     (queue_full),
      .push           (push),
      .push_entry     (push_entry)
   );

   tdsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   tdsp_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (head_valid),
      .head_entry          (head_entry),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_byte_role       (rsp_byte_role),
      .rsp_field_position  (rsp_field_position),
      .rsp_field_last      (rsp_field_last),
      .rsp_entry_type      (rsp_entry_type),
      .rsp_length_value    (rsp_length_value),
      .rsp_error_code      (rsp_error_code),
      .rsp_dictionary_done (rsp_dictionary_done)
   );

endmodule

`default_nettype wire
